[rtl/ppit_pkg.sv]
package ppit_pkg;

  // coordinate and field widths fixed by the word formats
  localparam int COORD_BITS = 12;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                  inside_res;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [COUNT_W-1:0]    vertex_count;
    logic [STATUS_W-1:0]   status;
  } out_word_t;

  // one vertex read back from the table, handed to the edge unit
  typedef struct packed {
    logic                  vld;
    logic                  first;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } edge_in_t;

endpackage

[rtl/ppit_edge_unit.sv]
module ppit_edge_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  ppit_pkg::edge_in_t                  edge_in,
  input  logic [ppit_pkg::COORD_BITS-1:0]     px,
  input  logic [ppit_pkg::COORD_BITS-1:0]     py,
  output logic                                odd_par
);

  localparam int CB = ppit_pkg::COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic [CB-1:0]        prev_col_r;
  logic [CB-1:0]        prev_row_r;
  logic signed [DW-1:0] ax;
  logic signed [DW-1:0] ay;
  logic signed [DW-1:0] bx;
  logic signed [DW-1:0] by;
  logic                 prev_below;
  logic                 cur_below;
  logic signed [PW-1:0] prod_a_r;
  logic signed [PW-1:0] prod_b_r;
  logic                 up_r;
  logic                 dn_r;
  logic                 s1_vld_r;
  logic signed [XW-1:0] cross_val;
  logic                 cross_pos;
  logic                 cross_neg;
  logic                 hit;
  logic                 parity_r;

  // edge end points relative to the test point
  assign ax = $signed({1'b0, prev_col_r}) - $signed({1'b0, px});
  assign ay = $signed({1'b0, prev_row_r}) - $signed({1'b0, py});
  assign bx = $signed({1'b0, edge_in.col}) - $signed({1'b0, px});
  assign by = $signed({1'b0, edge_in.row}) - $signed({1'b0, py});

  assign prev_below = prev_row_r <= py;
  assign cur_below  = edge_in.row <= py;

  // first stage: both products of the cross term, registered
  always_ff @(posedge clk) begin
    if (edge_in.vld) begin
      prev_col_r <= edge_in.col;
      prev_row_r <= edge_in.row;
      prod_a_r   <= ax * by;
      prod_b_r   <= ay * bx;
      up_r       <= cur_below && !prev_below;
      dn_r       <= !cur_below && prev_below;
    end
  end

  // second stage: sign of the cross product against crossing direction
  assign cross_val = XW'(prod_a_r) - XW'(prod_b_r);
  assign cross_neg = cross_val[XW-1];
  assign cross_pos = !cross_val[XW-1] && (cross_val != '0);
  assign hit       = s1_vld_r && ((up_r && cross_pos) || (dn_r && cross_neg));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      s1_vld_r <= edge_in.vld && !edge_in.first;
      if (clr) begin
        parity_r <= 1'b0;
      end else if (hit) begin
        parity_r <= !parity_r;
      end
    end
  end

  assign odd_par = parity_r;

endmodule

[rtl/polygon_point_inside_test.sv]
// channel  | ports                 | handshake
// ---------+-----------------------+------------------------------------------
// input    | start, busy, in_word  | word taken when start high and busy low
// result   | out_strobe, out_word  | word valid for one cycle, always taken
//
// clear and append words give their result in the next cycle; busy stays low
// a test on n stored vertices holds busy through the walk and the drain, and shows
// its result in the first cycle with busy low: one table read per edge plus first
// vertex, then the pipeline drain through the cross-product unit
// a test on fewer than three vertices answers in the next cycle
// reset is synchronous, active low; it empties the table and zeroes the box
// the receiver cannot stall: each result is shown for exactly one cycle
module polygon_point_inside_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ppit_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                out_strobe,
  output ppit_pkg::out_word_t out_word
);

  localparam int AW           = $clog2(MAX_VERTICES);
  localparam int CW           = $clog2(MAX_VERTICES + 1);
  localparam int CB           = ppit_pkg::COORD_BITS;
  localparam int OCW          = ppit_pkg::COUNT_W;
  localparam int DRAIN_CYCLES = 3;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] MIN_TEST  = CW'(3);
  localparam logic [1:0]    DRAIN_END = 2'(DRAIN_CYCLES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CB-1:0]    min_x_r, min_y_r, max_x_r, max_y_r;
  logic [CB-1:0]    min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic [ppit_pkg::STATUS_W-1:0] status_nxt;
  logic             accept;
  logic             wr_en;
  logic             go_test;
  logic             first_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    last_idx;
  logic [1:0]       drain_r;
  logic [CB-1:0]    px_r, py_r;
  logic             out_strobe_r;
  ppit_pkg::out_word_t out_word_r;

  // vertex table and its read port
  logic [2*CB-1:0]  vtx_mem [MAX_VERTICES];
  logic [2*CB-1:0]  rd_word_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             rd_vld_r;
  logic             rd_first_r;
  ppit_pkg::edge_in_t edge_in;
  logic             edge_par;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = state_r != ST_IDLE;
  assign last_idx = AW'(count_r - CW'(1));

  // table and box update for the accepted word
  always_comb begin
    count_nxt  = count_r;
    min_x_nxt  = min_x_r;
    min_y_nxt  = min_y_r;
    max_x_nxt  = max_x_r;
    max_y_nxt  = max_y_r;
    status_nxt = ppit_pkg::STATUS_OK;
    wr_en      = 1'b0;
    go_test    = 1'b0;
    if (accept) begin
      unique case (in_word.cmd)
        ppit_pkg::CMD_CLEAR: begin
          count_nxt = '0;
          min_x_nxt = '0;
          min_y_nxt = '0;
          max_x_nxt = '0;
          max_y_nxt = '0;
        end
        ppit_pkg::CMD_APPEND: begin
          if (count_r == MAX_COUNT) begin
            status_nxt = ppit_pkg::STATUS_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              min_x_nxt = in_word.x;
              max_x_nxt = in_word.x;
              min_y_nxt = in_word.y;
              max_y_nxt = in_word.y;
            end else begin
              if (in_word.x < min_x_r) min_x_nxt = in_word.x;
              if (in_word.x > max_x_r) max_x_nxt = in_word.x;
              if (in_word.y < min_y_r) min_y_nxt = in_word.y;
              if (in_word.y > max_y_r) max_y_nxt = in_word.y;
            end
          end
        end
        ppit_pkg::CMD_TEST: begin
          if (count_r < MIN_TEST) begin
            status_nxt = ppit_pkg::STATUS_SHORT;
          end else begin
            go_test = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk reads the last vertex first, then every vertex in order
  assign rd_en   = state_r == ST_WALK;
  assign rd_addr = first_r ? last_idx : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[count_r[AW-1:0]] <= {in_word.x, in_word.y};
    end
    if (rd_en) begin
      rd_word_r <= vtx_mem[rd_addr];
    end
  end

  assign edge_in.vld   = rd_vld_r;
  assign edge_in.first = rd_first_r;
  assign edge_in.col   = rd_word_r[2*CB-1:CB];
  assign edge_in.row   = rd_word_r[CB-1:0];

  ppit_edge_unit u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (accept),
    .edge_in (edge_in),
    .px      (px_r),
    .py      (py_r),
    .odd_par (edge_par)
  );

  // sequencer, state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      min_x_r      <= '0;
      min_y_r      <= '0;
      max_x_r      <= '0;
      max_y_r      <= '0;
      first_r      <= 1'b0;
      idx_r        <= '0;
      drain_r      <= '0;
      out_strobe_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_first_r   <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      rd_vld_r     <= rd_en;
      rd_first_r   <= first_r;
      count_r      <= count_nxt;
      min_x_r      <= min_x_nxt;
      min_y_r      <= min_y_nxt;
      max_x_r      <= max_x_nxt;
      max_y_r      <= max_y_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            px_r <= in_word.x;
            py_r <= in_word.y;
            if (go_test) begin
              state_r <= ST_WALK;
              first_r <= 1'b1;
              idx_r   <= '0;
            end else begin
              out_strobe_r            <= 1'b1;
              out_word_r.inside_res   <= 1'b0;
              out_word_r.min_x        <= min_x_nxt;
              out_word_r.min_y        <= min_y_nxt;
              out_word_r.max_x        <= max_x_nxt;
              out_word_r.max_y        <= max_y_nxt;
              out_word_r.vertex_count <= OCW'(count_nxt);
              out_word_r.status       <= status_nxt;
            end
          end
        end
        ST_WALK: begin
          if (first_r) begin
            first_r <= 1'b0;
          end else if (idx_r == last_idx) begin
            state_r <= ST_DRAIN;
            drain_r <= '0;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_r == DRAIN_END) begin
            state_r                 <= ST_IDLE;
            out_strobe_r            <= 1'b1;
            out_word_r.inside_res   <= edge_par;
            out_word_r.min_x        <= min_x_r;
            out_word_r.min_y        <= min_y_r;
            out_word_r.max_x        <= max_x_r;
            out_word_r.max_y        <= max_y_r;
            out_word_r.vertex_count <= OCW'(count_r);
            out_word_r.status       <= ppit_pkg::STATUS_OK;
          end else begin
            drain_r <= drain_r + 2'd1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // non-test words answer in the very next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.cmd != ppit_pkg::CMD_TEST)) |=> out_strobe)
    else $error("clear or append word gave no result in the next cycle");

  // the table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_COUNT)
    else $error("vertex count beyond table depth");

  // an edge walk only runs on a real polygon
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (count_r >= MIN_TEST))
    else $error("edge walk with fewer than three vertices");

  // every vertex read back was issued by the walk in the cycle before
  a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_WALK))
    else $error("table read data without a walk read");

endmodule

[verif/tb_polygon_point_inside_test.sv]
`timescale 1ns / 1ps

module tb_polygon_point_inside_test;

  localparam int CB           = ppit_pkg::COORD_BITS;
  localparam int CMDW         = ppit_pkg::CMD_W;
  localparam int CNTW         = ppit_pkg::COUNT_W;
  localparam int TABLE_DEPTH  = 64;
  localparam int TARGET_WORDS = 1600;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 20;
  localparam int COORD_MAX    = (1 << CB) - 1;

  // spare command code, no function in the block
  localparam logic [CMDW-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    ppit_pkg::in_word_t word;
    bit                 wait_idle;
  } stim_t;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  ppit_pkg::in_word_t  in_word = '0;
  logic                busy;
  logic                out_strobe;
  ppit_pkg::out_word_t out_word;

  // stimulus and result bookkeeping
  stim_t               stim_q [$];
  stim_t               cur_stim;
  ppit_pkg::out_word_t due_results [$];
  ppit_pkg::out_word_t exp_word;
  int        in_flight   = 0;
  int        words_sent  = 0;
  int        gap_left    = 0;
  int        burst_left  = 0;
  int        idle_cycles = 0;
  int        err_n       = 0;

  // coverage tallies
  int n_clear  = 0;
  int n_append = 0;
  int n_full   = 0;
  int n_test   = 0;
  int n_inside = 0;
  int n_short  = 0;
  int n_spare  = 0;

  // predictor state: vertex table and bounding box
  logic [CB-1:0] tbl_col [TABLE_DEPTH];
  logic [CB-1:0] tbl_row [TABLE_DEPTH];
  int unsigned   n_vert   = 0;
  logic [CB-1:0] box_lo_x = '0;
  logic [CB-1:0] box_lo_y = '0;
  logic [CB-1:0] box_hi_x = '0;
  logic [CB-1:0] box_hi_y = '0;

  polygon_point_inside_test #(
    .MAX_VERTICES (TABLE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always #6 clk = ~clk;

  // crossing-number parity over the closed edge list
  function automatic bit point_in_polygon(logic [CB-1:0] px,
                                          logic [CB-1:0] py);
    int unsigned prev;
    int unsigned hits;
    bit          prev_below;
    bit          cur_below;
    longint      ax, ay, bx, by, xprod;
    prev       = n_vert - 1;
    hits       = 0;
    prev_below = tbl_row[prev] <= py;
    for (int i = 0; i < n_vert; i++) begin
      cur_below = tbl_row[i] <= py;
      ax    = longint'(tbl_col[prev]) - longint'(px);
      ay    = longint'(tbl_row[prev]) - longint'(py);
      bx    = longint'(tbl_col[i]) - longint'(px);
      by    = longint'(tbl_row[i]) - longint'(py);
      xprod = ax * by - ay * bx;
      if (cur_below && !prev_below && xprod > 0) hits++;
      if (!cur_below && prev_below && xprod < 0) hits++;
      prev       = i;
      prev_below = cur_below;
    end
    return hits[0];
  endfunction

  // apply one word to the table and return the result it should give
  function automatic ppit_pkg::out_word_t apply_word(ppit_pkg::in_word_t w);
    ppit_pkg::out_word_t r;
    r        = '0;
    r.status = ppit_pkg::STATUS_OK;
    case (w.cmd)
      ppit_pkg::CMD_CLEAR: begin
        n_vert   = 0;
        box_lo_x = '0;
        box_lo_y = '0;
        box_hi_x = '0;
        box_hi_y = '0;
      end
      ppit_pkg::CMD_APPEND: begin
        if (n_vert >= TABLE_DEPTH) begin
          r.status = ppit_pkg::STATUS_FULL;
        end else begin
          if (n_vert == 0) begin
            box_lo_x = w.x;
            box_hi_x = w.x;
            box_lo_y = w.y;
            box_hi_y = w.y;
          end else begin
            if (w.x < box_lo_x) box_lo_x = w.x;
            if (w.x > box_hi_x) box_hi_x = w.x;
            if (w.y < box_lo_y) box_lo_y = w.y;
            if (w.y > box_hi_y) box_hi_y = w.y;
          end
          tbl_col[n_vert] = w.x;
          tbl_row[n_vert] = w.y;
          n_vert++;
        end
      end
      ppit_pkg::CMD_TEST: begin
        if (n_vert < 3) r.status = ppit_pkg::STATUS_SHORT;
        else r.inside_res = point_in_polygon(w.x, w.y);
      end
      default: begin
      end
    endcase
    r.min_x        = box_lo_x;
    r.min_y        = box_lo_y;
    r.max_x        = box_hi_x;
    r.max_y        = box_hi_y;
    r.vertex_count = CNTW'(n_vert);
    return r;
  endfunction

  function automatic void queue_word(logic [CMDW-1:0] cmd, int x, int y,
                                     bit wait_idle = 1'b0);
    stim_t s;
    s.word.cmd   = cmd;
    s.word.x     = CB'(x);
    s.word.y     = CB'(y);
    s.wait_idle  = wait_idle;
    stim_q.push_back(s);
  endfunction

  task automatic report_mismatch(string msg);
    err_n++;
    if (err_n <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // driver: bursts of words with random gaps, optional hold until idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) words_sent <= words_sent + 1;
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (stim_q.size() == 0) begin
          start <= 1'b0;
        end else if (stim_q[0].wait_idle && (in_flight != 0 || start)) begin
          start <= 1'b0;
        end else begin
          cur_stim = stim_q.pop_front();
          start   <= 1'b1;
          in_word <= cur_stim.word;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // monitor: predict on each accepted word, check each result strobe
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        exp_word = apply_word(in_word);
        due_results.push_back(exp_word);
        case (in_word.cmd)
          ppit_pkg::CMD_CLEAR:  n_clear++;
          ppit_pkg::CMD_APPEND: begin
            n_append++;
            if (exp_word.status == ppit_pkg::STATUS_FULL) n_full++;
          end
          ppit_pkg::CMD_TEST: begin
            n_test++;
            if (exp_word.status == ppit_pkg::STATUS_SHORT) n_short++;
            if (exp_word.inside_res) n_inside++;
          end
          default: n_spare++;
        endcase
      end
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with none due");
        end else begin
          exp_word = due_results.pop_front();
          if (out_word.inside_res !== exp_word.inside_res)
            report_mismatch($sformatf("inside_res got %b want %b",
                                      out_word.inside_res, exp_word.inside_res));
          if (out_word.min_x !== exp_word.min_x)
            report_mismatch($sformatf("min_x got %0d want %0d",
                                      out_word.min_x, exp_word.min_x));
          if (out_word.min_y !== exp_word.min_y)
            report_mismatch($sformatf("min_y got %0d want %0d",
                                      out_word.min_y, exp_word.min_y));
          if (out_word.max_x !== exp_word.max_x)
            report_mismatch($sformatf("max_x got %0d want %0d",
                                      out_word.max_x, exp_word.max_x));
          if (out_word.max_y !== exp_word.max_y)
            report_mismatch($sformatf("max_y got %0d want %0d",
                                      out_word.max_y, exp_word.max_y));
          if (out_word.vertex_count !== exp_word.vertex_count)
            report_mismatch($sformatf("vertex_count got %0d want %0d",
                                      out_word.vertex_count, exp_word.vertex_count));
          if (out_word.status !== exp_word.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_word.status, exp_word.status));
        end
      end
      in_flight <= in_flight + int'(start && !busy) - int'(out_strobe);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus build, reset and end of run
  initial begin
    int            n_poly, n_probe, span_x, span_y, lo_x, lo_y, pick, k;
    int            total;
    bit            few_rows;
    logic [CB-1:0] px, py;
    logic [CB-1:0] vx [$];
    logic [CB-1:0] vy [$];

    // directed: empty table, short polygons, corner triangle and square
    queue_word(ppit_pkg::CMD_TEST, 5, 5);
    queue_word(CMD_SPARE, COORD_MAX, COORD_MAX);
    queue_word(ppit_pkg::CMD_APPEND, 0, 0);
    queue_word(ppit_pkg::CMD_TEST, 0, 0);
    queue_word(ppit_pkg::CMD_APPEND, COORD_MAX, 0);
    queue_word(ppit_pkg::CMD_TEST, 10, 10);
    queue_word(ppit_pkg::CMD_APPEND, COORD_MAX, COORD_MAX);
    queue_word(ppit_pkg::CMD_TEST, 3000, 1000);
    queue_word(ppit_pkg::CMD_TEST, 1000, 3000);
    queue_word(ppit_pkg::CMD_TEST, 0, 0);
    queue_word(ppit_pkg::CMD_TEST, COORD_MAX, COORD_MAX);
    queue_word(ppit_pkg::CMD_TEST, 2048, 2048);
    queue_word(ppit_pkg::CMD_TEST, COORD_MAX, 2000);
    queue_word(ppit_pkg::CMD_TEST, 2000, 0);
    queue_word(CMD_SPARE, 0, 0);
    queue_word(ppit_pkg::CMD_APPEND, 0, COORD_MAX);
    queue_word(ppit_pkg::CMD_TEST, 2048, 2048);
    queue_word(ppit_pkg::CMD_TEST, COORD_MAX, COORD_MAX);
    queue_word(ppit_pkg::CMD_TEST, 0, COORD_MAX);
    queue_word(ppit_pkg::CMD_CLEAR, COORD_MAX, COORD_MAX);
    queue_word(ppit_pkg::CMD_TEST, 0, 0);
    queue_word(ppit_pkg::CMD_APPEND, 2047, 2048);
    queue_word(CMD_SPARE, 1365, 2730);

    // fill the table past its depth, starting from an idle block
    queue_word(ppit_pkg::CMD_CLEAR, 0, 0, 1'b1);
    repeat (TABLE_DEPTH + 2) queue_word(ppit_pkg::CMD_APPEND, $urandom, $urandom);
    repeat (3) queue_word(ppit_pkg::CMD_TEST, $urandom, $urandom);

    // random: mostly clear, build, probe sequences; some loose words
    while (stim_q.size() < TARGET_WORDS) begin
      if ($urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      n_poly = $urandom_range(3, 12);
        else if (pick < 85) n_poly = $urandom_range(13, TABLE_DEPTH);
        else if (pick < 92) n_poly = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 3);
        else                n_poly = $urandom_range(0, 2);
        span_x   = ($urandom_range(0, 3) == 0) ? COORD_MAX : $urandom_range(1, 600);
        span_y   = ($urandom_range(0, 3) == 0) ? COORD_MAX : $urandom_range(1, 600);
        lo_x     = $urandom_range(0, COORD_MAX - span_x);
        lo_y     = $urandom_range(0, COORD_MAX - span_y);
        few_rows = ($urandom_range(0, 4) == 0);
        queue_word(ppit_pkg::CMD_CLEAR, $urandom, $urandom, $urandom_range(0, 29) == 0);
        vx.delete();
        vy.delete();
        repeat (n_poly) begin
          px = CB'(lo_x + $urandom_range(0, span_x));
          // shared rows give horizontal edges and row-aligned vertices
          py = few_rows ? CB'(lo_y + span_y / 3 * $urandom_range(0, 3))
                        : CB'(lo_y + $urandom_range(0, span_y));
          vx.push_back(px);
          vy.push_back(py);
          queue_word(ppit_pkg::CMD_APPEND, int'(px), int'(py));
        end
        n_probe = $urandom_range(1, 8);
        repeat (n_probe) begin
          pick = $urandom_range(0, 9);
          if (pick < 5 || vx.size() == 0) begin
            px = CB'(lo_x - span_x / 4 + $urandom_range(0, span_x * 3 / 2));
            py = CB'(lo_y - span_y / 4 + $urandom_range(0, span_y * 3 / 2));
          end else if (pick < 7) begin
            k  = $urandom_range(0, vx.size() - 1);
            px = vx[k];
            py = vy[k];
          end else if (pick < 9) begin
            k  = $urandom_range(0, vx.size() - 1);
            px = CB'(lo_x + $urandom_range(0, span_x));
            py = vy[k];
          end else begin
            px = CB'($urandom);
            py = CB'($urandom);
          end
          queue_word(ppit_pkg::CMD_TEST, int'(px), int'(py));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          queue_word(CMDW'($urandom_range(ppit_pkg::CMD_CLEAR, CMD_SPARE)),
                     $urandom, $urandom);
      end
    end
    total = stim_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (words_sent != total || in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("covered %0d words: %0d clears, %0d appends (%0d dropped on a full table)",
             total, n_clear, n_append, n_full);
    $display("%0d point tests (%0d inside, %0d on too few vertices), %0d spare codes",
             n_test, n_inside, n_short, n_spare);
    if (err_n == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ppit_pkg.sv
rtl/ppit_edge_unit.sv
rtl/polygon_point_inside_test.sv
verif/tb_polygon_point_inside_test.sv
